### rtl/assert_macros.svh
// Assertion helpers, clocked on clk, off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true at a clock edge out of reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/tcfr_pkg.sv
package tcfr_pkg;

    localparam logic [7:0] HDR0       = 8'hAA;
    localparam logic [7:0] HDR1       = 8'hAF;
    localparam logic [7:0] CMD_GAINS  = 8'h12;
    localparam logic [7:0] CMD_RETURN = 8'h02;
    localparam logic [7:0] ACK_FUNC   = 8'hF0;
    localparam logic [7:0] ACK_LEN    = 8'h03;
    localparam logic [7:0] ACK_TAG    = 8'hBA;
    localparam logic [7:0] ACK_PAD    = 8'h00;

    // fixed part of the acknowledge checksum, mod 256
    localparam logic [7:0] ACK_BASE = 8'(HDR0 + HDR0 + ACK_FUNC + ACK_LEN + ACK_TAG + ACK_PAD);

    localparam logic [7:0] MAX_FRAME_LEN  = 8'd255;
    localparam logic [7:0] POS_HDR0       = 8'd0;
    localparam logic [7:0] POS_HDR1       = 8'd1;
    localparam logic [7:0] POS_CMD        = 8'd2;
    localparam logic [7:0] GAIN_FIRST_POS = 8'd4;
    localparam logic [7:0] GAIN_LAST_POS  = 8'd9;
    localparam int         GAIN_BYTES     = 6;
    localparam int         GAIN_IDX_W     = 3;

    localparam int ACK_BYTES = 8;
    localparam int ACK_IDX_W = 3;
    localparam logic [ACK_IDX_W-1:0] ACK_LAST_IDX = ACK_IDX_W'(ACK_BYTES - 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one accepted frame, as handed from parser to acknowledge sender
    typedef struct packed {
        logic [7:0]  sum;
        logic        updated;
        logic        ret;
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] kd;
    } frame_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [7:0] ack_byte_f(input logic [ACK_IDX_W-1:0] idx,
                                               input logic [7:0] sum);
        logic [7:0] b;
        case (idx)
            3'd0:    b = HDR0;
            3'd1:    b = HDR0;
            3'd2:    b = ACK_FUNC;
            3'd3:    b = ACK_LEN;
            3'd4:    b = ACK_TAG;
            3'd5:    b = ACK_PAD;
            3'd6:    b = sum;
            default: b = 8'(sum + ACK_BASE);
        endcase
        return b;
    endfunction

endpackage

### rtl/tcfr_parser.sv
module tcfr_parser
    import tcfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       frame_end,
    input  q_stat_t    q_stat,
    output logic       q_push,
    output frame_t     q_data
);

    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  hdr0_reg, hdr0_next;
    logic [7:0]  hdr1_reg, hdr1_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [15:0] kp_reg, ki_reg, kd_reg;
    logic [7:0]  gain_reg [GAIN_BYTES];

    logic                  accept;
    logic                  gain_wr;
    logic [GAIN_IDX_W-1:0] gain_idx;
    logic [7:0]            gain5;
    logic                  frame_ok;
    logic                  upd;
    logic [15:0]           kp_new, ki_new, kd_new;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign gain_wr  = pos_reg inside {[GAIN_FIRST_POS:GAIN_LAST_POS]};
    assign gain_idx = GAIN_IDX_W'(pos_reg - GAIN_FIRST_POS);

    always_comb
    begin
        hdr0_next = (pos_reg == POS_HDR0) ? rx_byte : hdr0_reg;
        hdr1_next = (pos_reg == POS_HDR1) ? rx_byte : hdr1_reg;
        cmd_next  = (pos_reg == POS_CMD) ? rx_byte : cmd_reg;
        sum_next  = 8'(sum_reg + rx_byte);
        pos_next  = (pos_reg < MAX_FRAME_LEN) ? 8'(pos_reg + 8'd1) : pos_reg;

        // the final byte may itself be the last gain byte
        gain5    = (pos_reg == GAIN_LAST_POS) ? rx_byte : gain_reg[GAIN_BYTES-1];
        frame_ok = (sum_reg == rx_byte) && (hdr0_next == HDR0) && (hdr1_next == HDR1);
        upd      = (cmd_next == CMD_GAINS) && (pos_reg >= GAIN_LAST_POS);

        kp_new = upd ? {gain_reg[0], gain_reg[1]} : kp_reg;
        ki_new = upd ? {gain_reg[2], gain_reg[3]} : ki_reg;
        kd_new = upd ? {gain_reg[4], gain5} : kd_reg;

        q_push         = accept && frame_end && frame_ok;
        q_data.sum     = sum_reg;
        q_data.updated = upd;
        q_data.ret     = (cmd_next == CMD_RETURN);
        q_data.kp      = kp_new;
        q_data.ki      = ki_new;
        q_data.kd      = kd_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            sum_reg  <= '0;
            hdr0_reg <= '0;
            hdr1_reg <= '0;
            cmd_reg  <= '0;
            kp_reg   <= '0;
            ki_reg   <= '0;
            kd_reg   <= '0;
        end
        else if (accept)
        begin
            if (frame_end)
            begin
                pos_reg  <= '0;
                sum_reg  <= '0;
                hdr0_reg <= '0;
                hdr1_reg <= '0;
                cmd_reg  <= '0;
                if (q_push)
                begin
                    kp_reg <= kp_new;
                    ki_reg <= ki_new;
                    kd_reg <= kd_new;
                end
            end
            else
            begin
                pos_reg  <= pos_next;
                sum_reg  <= sum_next;
                hdr0_reg <= hdr0_next;
                hdr1_reg <= hdr1_next;
                cmd_reg  <= cmd_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && gain_wr)
        begin
            gain_reg[gain_idx] <= rx_byte;
        end
    end

endmodule

### rtl/tcfr_queue.sv
module tcfr_queue
    import tcfr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  frame_t  push_data,
    input  logic    pop,
    output frame_t  pop_data,
    output q_stat_t stat
);

    frame_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
    endfunction

    assign stat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = QCNT_W'(cnt_reg + 1'b1);
            2'b01:   cnt_next = QCNT_W'(cnt_reg - 1'b1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/tcfr_ack_sender.sv
module tcfr_ack_sender
    import tcfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_stat_t     q_stat,
    input  frame_t      q_data,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  ack_byte,
    output logic        ack_last,
    output logic        gains_updated,
    output logic [15:0] kp_raw,
    output logic [15:0] ki_raw,
    output logic [15:0] kd_raw,
    output logic        return_request
);

    logic                 valid_reg, valid_next;
    logic [ACK_IDX_W-1:0] idx_reg, idx_next;
    frame_t               cur_reg, cur_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 advance;

    assign advance = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        cur_next   = cur_reg;
        byte_next  = byte_reg;
        q_pop      = 1'b0;
        if (advance)
        begin
            if (valid_reg && (idx_reg != ACK_LAST_IDX))
            begin
                idx_next  = ACK_IDX_W'(idx_reg + 1'b1);
                byte_next = ack_byte_f(idx_next, cur_reg.sum);
            end
            else if (!q_stat.empty)
            begin
                q_pop      = 1'b1;
                valid_next = 1'b1;
                cur_next   = q_data;
                idx_next   = '0;
                byte_next  = ack_byte_f('0, q_data.sum);
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        byte_reg <= byte_next;
    end

    assign out_valid      = valid_reg;
    assign ack_byte       = byte_reg;
    assign ack_last       = (idx_reg == ACK_LAST_IDX);
    assign gains_updated  = cur_reg.updated;
    assign kp_raw         = cur_reg.kp;
    assign ki_raw         = cur_reg.ki;
    assign kd_raw         = cur_reg.kd;
    assign return_request = cur_reg.ret;

endmodule

### rtl/telemetry_command_frame_receiver.sv
// Command frame receiver with additive checksum.
// Input channel (in_valid/in_ready): one frame byte per request in rx_byte,
// frame_end high on the final checksum byte. A byte is taken every cycle
// while the result queue has room.
// Output channel (out_valid/out_ready): each accepted frame (header AA AF,
// checksum equal to the 8-bit sum of the earlier bytes) yields eight requests,
// the acknowledge AA AA F0 03 BA 00 sum csum, ack_last on the eighth. Every
// request also carries the held gains after that frame, gains_updated
// (command 0x12 with ten or more bytes) and return_request (command 0x02).
// Rejected frames produce nothing and the parser restarts on the next byte.
// With the sender idle, a taken frame passes through the queue into the sender's
// output register; the sender then gives one byte per cycle while out_ready is
// high. A two-entry frame queue sits between the parser and the sender; when the
// receiver stalls, the sender holds its byte and in_ready drops only once both
// queue entries are full. Reset clears the parser, the held gains (to zero) and
// the queue; outputs go idle. The gain byte store is not cleared.
module telemetry_command_frame_receiver
    import tcfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  ack_byte,
    output logic        ack_last,
    output logic        gains_updated,
    output logic [15:0] kp_raw,
    output logic [15:0] ki_raw,
    output logic [15:0] kd_raw,
    output logic        return_request
);

`include "assert_macros.svh"

    q_stat_t q_stat;
    logic    q_push;
    logic    q_pop;
    frame_t  q_wdata;
    frame_t  q_rdata;

    tcfr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .frame_end (frame_end),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    tcfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .stat      (q_stat)
    );

    tcfr_ack_sender u_sender (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_stat         (q_stat),
        .q_data         (q_rdata),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .ack_byte       (ack_byte),
        .ack_last       (ack_last),
        .gains_updated  (gains_updated),
        .kp_raw         (kp_raw),
        .ki_raw         (ki_raw),
        .kd_raw         (kd_raw),
        .return_request (return_request)
    );

    `ASSERT_NEVER(a_no_push_full, q_push && q_stat.full, "frame pushed into full queue")
    `ASSERT_NEVER(a_no_pop_empty, q_pop && q_stat.empty, "frame popped from empty queue")
    `ASSERT_CLK(a_ack_continues, out_valid && out_ready && !ack_last |=> out_valid, "ack frame broken off")
    `ASSERT_CLK(a_ack_starts_hdr, $rose(out_valid) |-> (ack_byte == HDR0), "ack frame not starting with header")

endmodule

### tb/tcfr_checker.sv
module tcfr_checker
    import tcfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  ack_byte,
    input  logic        ack_last,
    input  logic        gains_updated,
    input  logic [15:0] kp_raw,
    input  logic [15:0] ki_raw,
    input  logic [15:0] kd_raw,
    input  logic        return_request,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0]  byte_val;
        logic        last;
        logic        updated;
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] kd;
        logic        ret;
    } ack_item_t;

    ack_item_t   ack_due[$];
    ack_item_t   want;

    logic [7:0]  pos;
    logic [7:0]  run_sum;
    logic [7:0]  hdr_a;
    logic [7:0]  hdr_b;
    logic [7:0]  cmd;
    logic [7:0]  gain_b [GAIN_BYTES];
    logic [15:0] kp_hold;
    logic [15:0] ki_hold;
    logic [15:0] kd_hold;

    initial begin
        errors  = 0;
        pending = 0;
        foreach (gain_b[i]) gain_b[i] = 8'h00;
    end

    task automatic restart_frame();
        pos     = 8'd0;
        run_sum = 8'd0;
        hdr_a   = 8'd0;
        hdr_b   = 8'd0;
        cmd     = 8'd0;
    endtask

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    // one frame byte: capture by position, sum, and judge the frame on its last byte
    task automatic parse_rx_byte(input logic [7:0] b, input logic last);
        logic [7:0] ack [8];
        logic [7:0] csum;
        logic       upd;
        logic       ret;
        ack_item_t  item;
        upd = 1'b0;
        ret = 1'b0;
        if (pos == POS_HDR0)
            hdr_a = b;
        else if (pos == POS_HDR1)
            hdr_b = b;
        else if (pos == POS_CMD)
            cmd = b;
        else if (pos >= GAIN_FIRST_POS && pos <= GAIN_LAST_POS)
            gain_b[pos - GAIN_FIRST_POS] = b;

        if (!last) begin
            run_sum = run_sum + b;
            if (pos != MAX_FRAME_LEN)
                pos = pos + 8'd1;
        end else begin
            if (run_sum == b && hdr_a == HDR0 && hdr_b == HDR1) begin
                // final byte at position 9 or later: ten bytes or more
                if (cmd == CMD_GAINS && pos >= GAIN_LAST_POS) begin
                    kp_hold = {gain_b[0], gain_b[1]};
                    ki_hold = {gain_b[2], gain_b[3]};
                    kd_hold = {gain_b[4], gain_b[5]};
                    upd     = 1'b1;
                end
                ret = (cmd == CMD_RETURN);
                ack = '{HDR0, HDR0, ACK_FUNC, ACK_LEN, ACK_TAG, ACK_PAD, run_sum, 8'h00};
                csum = 8'h00;
                for (int k = 0; k < 7; k++)
                    csum = csum + ack[k];
                ack[7] = csum;
                for (int k = 0; k < 8; k++) begin
                    item.byte_val = ack[k];
                    item.last     = (k == 7);
                    item.updated  = upd;
                    item.kp       = kp_hold;
                    item.ki       = ki_hold;
                    item.kd       = kd_hold;
                    item.ret      = ret;
                    ack_due.push_back(item);
                end
            end
            restart_frame();
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            restart_frame();
            kp_hold = 16'h0000;
            ki_hold = 16'h0000;
            kd_hold = 16'h0000;
            ack_due.delete();
            pending = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (ack_due.size() == 0) begin
                    $display("%0t: unexpected ack request, expected none, got byte %h",
                             $time, ack_byte);
                    errors++;
                end else begin
                    want = ack_due.pop_front();
                    check_field("ack_byte", 16'(want.byte_val), 16'(ack_byte));
                    check_field("ack_last", 16'(want.last), 16'(ack_last));
                    check_field("gains_updated", 16'(want.updated), 16'(gains_updated));
                    check_field("kp_raw", want.kp, kp_raw);
                    check_field("ki_raw", want.ki, ki_raw);
                    check_field("kd_raw", want.kd, kd_raw);
                    check_field("return_request", 16'(want.ret), 16'(return_request));
                end
            end
            if (in_valid && in_ready)
                parse_rx_byte(rx_byte, frame_end);
            pending = ack_due.size();
        end
    end

endmodule

### tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tcfr_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int BYTE_TARGET  = 250;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        frame_end;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  ack_byte;
    logic        ack_last;
    logic        gains_updated;
    logic [15:0] kp_raw;
    logic [15:0] ki_raw;
    logic [15:0] kd_raw;
    logic        return_request;
    int          errors;
    int          pending;

    logic [7:0]  frame_buf[$];
    int          bytes_sent;
    int          burst_left;
    bit          no_gaps;
    bit          hold_now;
    bit          hold_done;
    int          cycle_count;

    telemetry_command_frame_receiver u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .frame_end      (frame_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .ack_byte       (ack_byte),
        .ack_last       (ack_last),
        .gains_updated  (gains_updated),
        .kp_raw         (kp_raw),
        .ki_raw         (ki_raw),
        .kd_raw         (kd_raw),
        .return_request (return_request)
    );

    tcfr_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .frame_end      (frame_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .ack_byte       (ack_byte),
        .ack_last       (ack_last),
        .gains_updated  (gains_updated),
        .kp_raw         (kp_raw),
        .ki_raw         (ki_raw),
        .kd_raw         (kd_raw),
        .return_request (return_request),
        .errors         (errors),
        .pending        (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: random stall pattern, plus one long hold-off when asked
    initial begin
        int stall_mode;
        int stall_left;
        stall_mode = 0;
        stall_left = 0;
        out_ready  = 1'b0;
        hold_done  = 1'b0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_now && !hold_done) begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end else begin
                if (stall_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    stall_left = $urandom_range(16, 80);
                end
                stall_left--;
                case (stall_mode)
                    0:       out_ready = 1'b1;
                    1:       out_ready = 1'($urandom_range(0, 1));
                    2:       out_ready = (stall_left % 4 == 0);
                    default: out_ready = ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        in_valid  = 1'b1;
        rx_byte   = b;
        frame_end = last;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    // sender bursts: a random gap before each new burst unless gaps are off
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge clk);
                in_valid  = 1'b0;
                rx_byte   = 8'($urandom);
                frame_end = 1'($urandom);
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++) begin
            pace();
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        end
    endtask

    // append the checksum byte, corrupted when good is clear
    task automatic close_frame(input bit good);
        logic [7:0] s;
        s = 8'h00;
        foreach (frame_buf[i]) s = s + frame_buf[i];
        if (!good)
            s = s ^ 8'($urandom_range(1, 255));
        frame_buf.push_back(s);
    endtask

    // len counts the checksum byte
    task automatic build_frame(input logic [7:0] h0, input logic [7:0] h1,
                               input logic [7:0] c, input int len, input bit good);
        frame_buf.delete();
        for (int i = 0; i < len - 1; i++) begin
            case (i)
                0:       frame_buf.push_back(h0);
                1:       frame_buf.push_back(h1);
                2:       frame_buf.push_back(c);
                default: frame_buf.push_back(8'($urandom));
            endcase
        end
        close_frame(good);
    endtask

    initial begin
        int         pick;
        bit         good;
        logic [7:0] h0;
        logic [7:0] h1;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        rx_byte       = 8'h00;
        frame_end     = 1'b0;
        bytes_sent    = 0;
        burst_left    = 0;
        no_gaps       = 1'b0;
        hold_now      = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // lone byte, then a two-byte frame whose checksum lands on header byte 1
        frame_buf = '{8'h00};
        send_frame();
        frame_buf = '{HDR0, HDR1};
        send_frame();
        build_frame(HDR0, HDR1, CMD_RETURN, 4, 1'b1);
        send_frame();
        build_frame(HDR0, HDR1, 8'h55, 4, 1'b1);
        send_frame();
        // gain command too short to load
        frame_buf = '{HDR0, HDR1, CMD_GAINS, 8'h00, 8'hFF};
        close_frame(1'b1);
        send_frame();
        // exactly ten bytes: the checksum doubles as the last gain byte
        frame_buf = '{HDR0, HDR1, CMD_GAINS, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h80};
        close_frame(1'b1);
        send_frame();

        hold_now = 1'b1;
        while (bytes_sent < BYTE_TARGET) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            pick    = $urandom_range(0, 99);
            good    = ($urandom_range(0, 9) != 0);
            h0      = HDR0;
            h1      = HDR1;
            if ($urandom_range(0, 11) == 0) h0 = 8'($urandom);
            if ($urandom_range(0, 11) == 0) h1 = 8'($urandom);
            if (pick < 50)
                build_frame(h0, h1, CMD_GAINS, $urandom_range(10, 16), good);
            else if (pick < 65)
                build_frame(h0, h1, CMD_RETURN, $urandom_range(3, 8), good);
            else if (pick < 75)
                build_frame(h0, h1, CMD_GAINS, $urandom_range(3, 9), good);
            else if (pick < 88)
                build_frame(h0, h1, 8'($urandom), $urandom_range(3, 12), good);
            else begin
                frame_buf.delete();
                repeat ($urandom_range(1, 6)) frame_buf.push_back(8'($urandom));
            end
            send_frame();
        end
        @(negedge clk);
        in_valid  = 1'b0;
        frame_end = 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
